[design/hbd_pkg.sv]
// Shared types and constants for the H-bridge direction and dead-time driver.
package hbd_pkg;

  localparam int MAG_W   = 15;
  localparam int LIMIT_W = 15;
  localparam int DEAD_W  = 24;
  localparam int CFG_W   = 24;
  localparam int IDX_W   = 8;

  localparam logic [LIMIT_W-1:0] OVER_LIMIT_RST  = 15'd31130;
  localparam logic [LIMIT_W-1:0] UNDER_LIMIT_RST = 15'd1638;
  localparam logic [DEAD_W-1:0]  DEAD_TIME_RST   = 24'd10000;

  typedef enum logic [IDX_W-1:0] {
    IDX_OVER_LIMIT  = 8'd0,
    IDX_UNDER_LIMIT = 8'd1,
    IDX_DEAD_TIME   = 8'd2,
    IDX_REVERSE     = 8'd3
  } cfg_idx_t;

  typedef enum logic {
    REQ_DUTY = 1'b0,
    REQ_TICK = 1'b1
  } req_kind_t;

  typedef struct packed {
    logic [LIMIT_W-1:0] over_limit;
    logic [LIMIT_W-1:0] under_limit;
    logic [DEAD_W-1:0]  dead_time;
    logic               reverse;
  } cfg_t;

  typedef struct packed {
    logic             forward_pin;
    logic             backward_pin;
    logic [MAG_W-1:0] pwm_magnitude;
  } drv_t;

endpackage

[design/hbd_req_if.sv]
// Request channel: duty requests and ticks.
interface hbd_req_if #(
  parameter int DUTY_BITS = 16
);
  logic                        valid;
  logic                        ready;
  logic                        req_type;
  logic signed [DUTY_BITS-1:0] duty_request;

  modport source (output valid, output req_type, output duty_request, input ready);
  modport sink   (input valid, input req_type, input duty_request, output ready);
endinterface

[design/hbd_drv_if.sv]
// Drive channel: direction pins and PWM magnitude.
interface hbd_drv_if;
  logic        valid;
  logic        ready;
  logic        forward_pin;
  logic        backward_pin;
  logic [14:0] pwm_magnitude;

  modport source (output valid, output forward_pin, output backward_pin,
                  output pwm_magnitude, input ready);
  modport sink   (input valid, input forward_pin, input backward_pin,
                  input pwm_magnitude, output ready);
endinterface

[design/hbd_duty_cond.sv]
// Duty conditioner: clamp to the over-limit, zero below the under-limit.
module hbd_duty_cond
  import hbd_pkg::*;
#(
  parameter int DUTY_BITS = 16
) (
  input  logic signed [DUTY_BITS-1:0] duty_in,
  input  cfg_t                        cfg,
  output logic signed [DUTY_BITS-1:0] duty_out
);

  // wide enough for the duty range and for plus or minus a 15-bit limit
  localparam int CW = ((DUTY_BITS > LIMIT_W + 1) ? DUTY_BITS : LIMIT_W + 1) + 1;

  logic signed [CW-1:0] d_ext;
  logic signed [CW-1:0] lim;
  logic signed [CW-1:0] under;
  logic signed [CW-1:0] clamped;
  logic signed [CW-1:0] mag;

  always_comb begin
    d_ext = CW'(duty_in);
    lim   = $signed({{(CW-LIMIT_W){1'b0}}, cfg.over_limit});
    under = $signed({{(CW-LIMIT_W){1'b0}}, cfg.under_limit});
    clamped = d_ext;
    if (d_ext > lim) begin
      clamped = lim;
    end else if (d_ext < -lim) begin
      clamped = -lim;
    end
    mag = (clamped < 0) ? -clamped : clamped;
    if (mag < under) begin
      clamped = '0;
    end
    // clamped never leaves the input range, so the cut is lossless
    duty_out = clamped[DUTY_BITS-1:0];
  end

endmodule

[design/hbd_drive.sv]
// Drive state: stored duty, direction, dead-time counter and pin decode.
module hbd_drive
  import hbd_pkg::*;
#(
  parameter int TIMER_BITS = 24,
  parameter int DUTY_BITS  = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        load,
  input  logic                        tick,
  input  logic signed [DUTY_BITS-1:0] duty_in,
  input  cfg_t                        cfg,
  output drv_t                        result
);

  localparam int EW = (TIMER_BITS > DEAD_W) ? TIMER_BITS : DEAD_W;
  localparam int MW = DUTY_BITS + MAG_W + 1;

  logic signed [DUTY_BITS-1:0] stored_duty;
  logic                        last_direction;
  logic [TIMER_BITS-1:0]       elapsed_ticks;

  logic [TIMER_BITS-1:0] elapsed_next;
  logic                  last_direction_next;
  logic                  in_dead;
  logic signed [MW-1:0]  duty_wide;
  logic signed [MW-1:0]  mag_wide;

  always_comb begin
    elapsed_next        = (elapsed_ticks != '1) ? elapsed_ticks + 1'b1 : elapsed_ticks;
    last_direction_next = last_direction;
    // direction change restarts the dead time
    if (stored_duty > 0 && last_direction) begin
      elapsed_next        = '0;
      last_direction_next = 1'b0;
    end
    if (stored_duty < 0 && !last_direction) begin
      elapsed_next        = '0;
      last_direction_next = 1'b1;
    end
    in_dead = EW'(elapsed_next) < EW'(cfg.dead_time);

    duty_wide = MW'(stored_duty);
    mag_wide  = (duty_wide < 0) ? -duty_wide : duty_wide;

    if (in_dead || stored_duty == '0) begin
      // brake
      result.forward_pin   = 1'b1;
      result.backward_pin  = 1'b1;
      result.pwm_magnitude = '0;
    end else begin
      result.forward_pin   = (stored_duty > 0) ? !cfg.reverse : cfg.reverse;
      result.backward_pin  = (stored_duty > 0) ? cfg.reverse : !cfg.reverse;
      result.pwm_magnitude = mag_wide[MAG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stored_duty    <= '0;
      last_direction <= 1'b0;
      elapsed_ticks  <= '0;
    end else begin
      if (load) begin
        stored_duty <= duty_in;
      end
      if (tick) begin
        elapsed_ticks  <= elapsed_next;
        last_direction <= last_direction_next;
      end
    end
  end

endmodule

[design/hbd_out_skid.sv]
// Output register with a skid entry so input flow survives one stalled item.
module hbd_out_skid
  import hbd_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  drv_t push_data,
  output logic space,
  hbd_drv_if.source drv
);

  logic out_valid;
  drv_t out_data;
  logic skid_valid;
  drv_t skid_data;
  logic pop;

  assign pop   = out_valid && drv.ready;
  assign space = !skid_valid;

  assign drv.valid         = out_valid;
  assign drv.forward_pin   = out_data.forward_pin;
  assign drv.backward_pin  = out_data.backward_pin;
  assign drv.pwm_magnitude = out_data.pwm_magnitude;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid || pop) begin
        out_data  <= push_data;
        out_valid <= 1'b1;
      end else begin
        skid_data  <= push_data;
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

endmodule

[design/hbridge_direction_deadtime.sv]
// H-bridge driver top level: config registers, duty conditioning, drive, output.
// Throughput: one item per cycle while the skid entry is free. A tick's drive item
// goes to the output register, or to the skid entry on a stall, so one result can
// wait while the next item is taken. Duty requests give no output item.
// Reset (rst, synchronous): registers to defaults, duty zero, clockwise, counter
// zero so the dead time runs from reset, output empty.
module hbridge_direction_deadtime
  import hbd_pkg::*;
#(
  parameter int TIMER_BITS = 24,
  parameter int DUTY_BITS  = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata,
  hbd_req_if.sink          req,
  hbd_drv_if.source        drv
);

  cfg_t cfg;

  // Configuration writes; unknown indexes fall through and are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.over_limit  <= OVER_LIMIT_RST;
      cfg.under_limit <= UNDER_LIMIT_RST;
      cfg.dead_time   <= DEAD_TIME_RST;
      cfg.reverse     <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        IDX_OVER_LIMIT:  cfg.over_limit  <= cfg_wdata[LIMIT_W-1:0];
        IDX_UNDER_LIMIT: cfg.under_limit <= cfg_wdata[LIMIT_W-1:0];
        IDX_DEAD_TIME:   cfg.dead_time   <= cfg_wdata[DEAD_W-1:0];
        IDX_REVERSE:     cfg.reverse     <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  logic                        space;
  logic                        accept;
  logic                        load;
  logic                        tick;
  logic signed [DUTY_BITS-1:0] duty_cond;
  drv_t                        result;

  // Accept whenever the skid entry is free; duty requests never need space
  // but sharing one ready keeps the handshake simple.
  assign req.ready = space;
  assign accept    = req.valid && space;
  assign load      = accept && (req.req_type == REQ_DUTY);
  assign tick      = accept && (req.req_type == REQ_TICK);

  hbd_duty_cond #(
    .DUTY_BITS(DUTY_BITS)
  ) u_cond (
    .duty_in (req.duty_request),
    .cfg     (cfg),
    .duty_out(duty_cond)
  );

  // State update and drive decode happen in the accepting cycle; the result
  // is captured by the output register below.
  hbd_drive #(
    .TIMER_BITS(TIMER_BITS),
    .DUTY_BITS (DUTY_BITS)
  ) u_drive (
    .clk    (clk),
    .rst    (rst),
    .load   (load),
    .tick   (tick),
    .duty_in(duty_cond),
    .cfg    (cfg),
    .result (result)
  );

  hbd_out_skid u_out (
    .clk      (clk),
    .rst      (rst),
    .push     (tick),
    .push_data(result),
    .space    (space),
    .drv      (drv)
  );

endmodule

[test/hbridge_direction_deadtime_tb.sv]
// Testbench for the H-bridge direction and dead-time driver: directed and random checks.
`timescale 1ns / 100ps

module hbridge_direction_deadtime_tb;
  import hbd_pkg::*;

  localparam int TICK_W = 24;
  localparam int DUTY_W = 16;

  // Register index past the end of the map; writes to it must be dropped.
  localparam logic [IDX_W-1:0] IDX_NONE = 8'd200;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_wdata;

  hbd_req_if #(.DUTY_BITS(DUTY_W)) req_ch ();
  hbd_drv_if drv_ch ();

  hbridge_direction_deadtime #(
    .TIMER_BITS(TICK_W),
    .DUTY_BITS (DUTY_W)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .req      (req_ch),
    .drv      (drv_ch)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Drive predictor: shadow registers and bridge state.
  // ---------------------------------------------------------------------------
  logic [LIMIT_W-1:0] over_lim;
  logic [LIMIT_W-1:0] under_lim;
  logic [DEAD_W-1:0]  dead_ticks;
  logic               rev_pins;
  int                 duty_held;   // conditioned duty, already clamped
  logic               dir_ccw;     // last direction, 0 = clockwise
  logic [TICK_W-1:0]  elapsed;

  drv_t pending_drives[$];         // drive items still owed by the block
  int   mismatch_count = 0;

  int send_idle_pct  = 0;          // chance per cycle that the sender holds off
  int recv_stall_pct = 0;          // chance per cycle that the receiver stalls

  task automatic reset_model();
    over_lim   = OVER_LIMIT_RST;
    under_lim  = UNDER_LIMIT_RST;
    dead_ticks = DEAD_TIME_RST;
    rev_pins   = 1'b0;
    duty_held  = 0;
    dir_ccw    = 1'b0;
    elapsed    = '0;
  endtask

  task automatic apply_reg(logic [IDX_W-1:0] index, logic [CFG_W-1:0] value);
    case (index)
      IDX_OVER_LIMIT:  over_lim   = value[LIMIT_W-1:0];
      IDX_UNDER_LIMIT: under_lim  = value[LIMIT_W-1:0];
      IDX_DEAD_TIME:   dead_ticks = value[DEAD_W-1:0];
      IDX_REVERSE:     rev_pins   = value[0];
      default: ;       // unmapped index: no effect
    endcase
  endtask

  // Duty request: clamp to +/- over limit, then zero anything under the floor.
  // Tick: advance the saturating counter, restart it on a direction flip, and
  // hold the bridge in brake until the dead time has run out.
  task automatic predict_drive(req_kind_t kind, logic signed [DUTY_W-1:0] duty);
    int   d;
    int   lim;
    int   mag;
    int   drive_val;
    drv_t want;
    if (kind == REQ_DUTY) begin
      d   = int'(duty);
      lim = int'(over_lim);
      if (d > lim) d = lim;
      if (d < -lim) d = -lim;
      mag = (d < 0) ? -d : d;
      if (mag < int'(under_lim)) d = 0;
      duty_held = d;
    end else begin
      if (elapsed != {TICK_W{1'b1}}) elapsed = elapsed + 1'b1;
      if (duty_held > 0 && dir_ccw) begin
        elapsed = '0;
        dir_ccw = 1'b0;
      end
      if (duty_held < 0 && !dir_ccw) begin
        elapsed = '0;
        dir_ccw = 1'b1;
      end
      drive_val = (elapsed < dead_ticks) ? 0 : duty_held;
      if (drive_val > 0) begin
        want.forward_pin   = ~rev_pins;
        want.backward_pin  = rev_pins;
        want.pwm_magnitude = MAG_W'(drive_val);
      end else if (drive_val < 0) begin
        want.forward_pin   = rev_pins;
        want.backward_pin  = ~rev_pins;
        want.pwm_magnitude = MAG_W'(-drive_val);
      end else begin
        // brake: both low-side paths on, no PWM
        want.forward_pin   = 1'b1;
        want.backward_pin  = 1'b1;
        want.pwm_magnitude = '0;
      end
      pending_drives.push_back(want);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Drive channel: random backpressure and the result check.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    drv_ch.ready <= (recv_stall_pct == 0) || ($urandom_range(99, 0) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    drv_t want;
    if (!rst && drv_ch.valid && drv_ch.ready) begin
      if (pending_drives.size() == 0) begin
        $display("%0t: unexpected drive item fwd=%0b bwd=%0b mag=%0d", $time,
                 drv_ch.forward_pin, drv_ch.backward_pin, drv_ch.pwm_magnitude);
        mismatch_count++;
      end else begin
        want = pending_drives.pop_front();
        if (drv_ch.forward_pin !== want.forward_pin) begin
          $display("%0t: forward_pin expected %0b, got %0b", $time,
                   want.forward_pin, drv_ch.forward_pin);
          mismatch_count++;
        end
        if (drv_ch.backward_pin !== want.backward_pin) begin
          $display("%0t: backward_pin expected %0b, got %0b", $time,
                   want.backward_pin, drv_ch.backward_pin);
          mismatch_count++;
        end
        if (drv_ch.pwm_magnitude !== want.pwm_magnitude) begin
          $display("%0t: pwm_magnitude expected %0d, got %0d", $time,
                   want.pwm_magnitude, drv_ch.pwm_magnitude);
          mismatch_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Shared stimulus helpers. Every task is entered just after a rising edge.
  // ---------------------------------------------------------------------------

  // Offer one item, with random hold-off first; returns once it is taken.
  task automatic send_item(req_kind_t kind, logic signed [DUTY_W-1:0] duty);
    while (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.req_type     <= kind;
    req_ch.duty_request <= duty;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    predict_drive(kind, duty);
  endtask

  // Stop sending and let every owed drive item come out, then wait out a trailing
  // duty request that produces nothing.
  task automatic settle();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_drives.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // One register write; we drops on the following cycle.
  task automatic write_reg(logic [IDX_W-1:0] index, logic [CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= value;
    @(posedge clk);
    apply_reg(index, value);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic tick();
    send_item(REQ_TICK, DUTY_W'($urandom));
  endtask

  // Duty values biased toward the clamp and floor edges.
  function automatic logic signed [DUTY_W-1:0] pick_duty();
    int mag;
    int sgn;
    sgn = $urandom_range(0, 1) ? -1 : 1;
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      1: return '0;
      2: mag = int'(under_lim) + int'($urandom_range(0, 2)) - 1;
      3: mag = int'(over_lim) + int'($urandom_range(0, 2)) - 1;
      4, 5: mag = int'($urandom_range(0, 300));
      default: return DUTY_W'($urandom_range(0, 65535));
    endcase
    return DUTY_W'(sgn * mag);
  endfunction

  // Fresh register set for a random block; extremes come up often.
  task automatic pick_settings();
    logic [CFG_W-1:0] v;
    case ($urandom_range(0, 3))
      0: v = '0;
      1: v = CFG_W'(32767);
      default: v = CFG_W'($urandom_range(0, 32767));
    endcase
    write_reg(IDX_OVER_LIMIT, v);
    case ($urandom_range(0, 4))
      0: v = '0;
      1: v = CFG_W'(32767);
      2: v = CFG_W'($urandom_range(0, 32767));
      default: v = CFG_W'($urandom_range(0, 2000));
    endcase
    write_reg(IDX_UNDER_LIMIT, v);
    // long dead times only rarely, they pin the bridge in brake
    case ($urandom_range(0, 9))
      0: v = '0;
      1: v = 24'hFFFFFF;
      2: v = CFG_W'($urandom_range(0, 24'hFFFFFF));
      default: v = CFG_W'($urandom_range(1, 10));
    endcase
    write_reg(IDX_DEAD_TIME, v);
    write_reg(IDX_REVERSE, CFG_W'($urandom_range(0, 1)));
    if ($urandom_range(0, 3) == 0)
      write_reg(IDX_W'($urandom_range(IDX_REVERSE + 1, 255)), CFG_W'($urandom));
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Right after reset the dead time is running: every tick must brake.
  task automatic test_reset_brake();
    send_item(REQ_DUTY, 16'sh7FFF);
    tick();
    send_item(REQ_DUTY, -16'sd5000);
    tick();
    settle();
  endtask

  // Reset limits with dead time off; an unmapped write must change nothing.
  task automatic test_default_limits();
    write_reg(IDX_DEAD_TIME, '0);
    write_reg(IDX_NONE, {CFG_W{1'b1}});
    send_item(REQ_DUTY, 16'sh7FFF);        // clamps to reset over limit
    tick();
    send_item(REQ_DUTY, 16'sd1637);        // just under the floor
    tick();
    send_item(REQ_DUTY, 16'sd1638);        // right at the floor
    tick();
    send_item(REQ_DUTY, 16'sh8000);        // most negative, flips direction
    tick();
    settle();
  endtask

  // Full-scale limits with swapped pins, zero duty, and a floor above the clamp.
  task automatic test_limit_extremes();
    write_reg(IDX_OVER_LIMIT, CFG_W'(32767));
    write_reg(IDX_UNDER_LIMIT, '0);
    write_reg(IDX_REVERSE, CFG_W'(1));
    send_item(REQ_DUTY, 16'sh8000);
    tick();
    send_item(REQ_DUTY, 16'sh7FFF);
    tick();
    send_item(REQ_DUTY, '0);
    tick();
    settle();
    write_reg(IDX_OVER_LIMIT, CFG_W'(100));
    write_reg(IDX_UNDER_LIMIT, CFG_W'(200));
    send_item(REQ_DUTY, 16'sd150);         // clamped, then zeroed
    tick();
    settle();
  endtask

  // Direction change restarts the counter: two brake ticks, then drive.
  task automatic test_dead_time_flip();
    write_reg(IDX_OVER_LIMIT, CFG_W'(32767));
    write_reg(IDX_UNDER_LIMIT, '0);
    write_reg(IDX_REVERSE, '0);
    write_reg(IDX_DEAD_TIME, CFG_W'(2));
    send_item(REQ_DUTY, -16'sd100);
    tick();
    tick();
    tick();
    settle();
  endtask

  // Random blocks: a duty request followed by a burst of ticks, so direction
  // flips and dead-time expiry happen often. Now and then requests come back
  // to back with no tick between them.
  task automatic test_random_traffic(int idle_pct, int stall_pct, int n_items);
    int sent;
    int block_end;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    while (sent < n_items) begin
      pick_settings();
      block_end = sent + 120;
      while (sent < block_end && sent < n_items) begin
        send_item(REQ_DUTY, pick_duty());
        sent++;
        if ($urandom_range(0, 7) != 0) begin
          repeat ($urandom_range(1, 12)) begin
            tick();
            sent++;
          end
        end
      end
      settle();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst                 = 1'b1;
    cfg_we              = 1'b0;
    cfg_index           = '0;
    cfg_wdata           = '0;
    req_ch.valid        = 1'b0;
    req_ch.req_type     = REQ_DUTY;
    req_ch.duty_request = '0;
    drv_ch.ready        = 1'b1;
    reset_model();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_reset_brake();
    test_default_limits();
    test_limit_extremes();
    test_dead_time_flip();
    test_random_traffic(0, 0, 470);
    test_random_traffic(86, 0, 470);
    test_random_traffic(0, 86, 470);
    test_random_traffic(24, 24, 470);

    if (mismatch_count == 0) begin
      $display("hbridge_direction_deadtime_tb: done, clean");
    end else begin
      $display("hbridge_direction_deadtime_tb: done, errors");
    end
    $finish;
  end

  // Hang guard, far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("hbridge_direction_deadtime_tb: done, errors");
    $finish;
  end

endmodule

[hbridge_direction_deadtime.f]
design/hbd_pkg.sv
design/hbd_req_if.sv
design/hbd_drv_if.sv
design/hbd_duty_cond.sv
design/hbd_drive.sv
design/hbd_out_skid.sv
design/hbridge_direction_deadtime.sv
test/hbridge_direction_deadtime_tb.sv
